>>> src/bfla_pkg.sv
`default_nettype none

package bfla_pkg;

  localparam int NUM_BLOCKS    = 1024;
  localparam int NODE_CAPACITY = 16;

  // Block indices travel as 10-bit fields.
  localparam int BLK_W     = 10;
  localparam int CNT_W     = $clog2(NODE_CAPACITY + 1);
  localparam int ENT_DEPTH = NUM_BLOCKS * NODE_CAPACITY;
  localparam int ENT_AW    = $clog2(ENT_DEPTH);

  typedef enum logic {
    CMD_FREE  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

  // Header of one list node: link to the next node and number of stored entries.
  typedef struct packed {
    logic             link_vld;
    logic [BLK_W-1:0] link;
    logic [CNT_W-1:0] cnt;
  } hdr_t;

endpackage

`default_nettype wire

>>> src/block_free_list_allocator_core.sv
// Free-block allocator with the free list kept inside the free blocks.
// Slave channel (s_axis_*): one request per item. tuser carries the command
// (free or allocate), tdata the index of the block being freed.
// Master channel (m_axis_*): one result per request: the allocated block, an
// error flag in tuser for an allocate on an empty list, and the list-empty flag.
// The head node header is cached in registers and every change of it is also
// written to memory. Node headers and node entries live in two single-port
// synchronous memories with registered reads.
// A free, an allocate on an empty list and an allocate that hands out the head
// node itself present their result in the cycle after acceptance. An allocate
// that takes an entry presents it after the entry memory read, from the read
// register through the output register. An allocate that hands out a head node
// with a valid link keeps the block busy in S_HDR while the next node header
// is read. No new request is taken while an entry or header read is under way.
// The output register parts the two sides: a new request is taken while a
// result still waits, as long as the register is freed in that cycle. When
// the receiver stalls, the result holds and no further request is taken.
// After reset the list is empty; the memories need no clearing, since an
// entry is read only after it was written.
`default_nettype none

module block_free_list_allocator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [9:0] block_id, [15:10] zero
  input  wire logic [15:0] s_axis_tdata_i,
  // [0] command
  input  wire logic [0:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [9:0] alloc_block, [10] list_empty, [15:11] zero
  output logic [15:0]      m_axis_tdata_o,
  // [0] alloc_error
  output logic [0:0]       m_axis_tuser_o
);

  localparam int BLK_W = bfla_pkg::BLK_W;
  localparam int CNT_W = bfla_pkg::CNT_W;
  localparam int ENT_AW = bfla_pkg::ENT_AW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENTRY,
    S_HDR
  } state_e;

  state_e state_q, state_d;

  logic             head_valid_q, head_valid_d;
  logic [BLK_W-1:0] head_q, head_d;
  bfla_pkg::hdr_t   hdr_q, hdr_d;

  logic             out_valid_q, out_valid_d;
  logic [BLK_W-1:0] out_block_q, out_block_d;
  logic             out_err_q, out_err_d;
  logic             out_empty_q, out_empty_d;

  logic                    acc;
  bfla_pkg::cmd_e          cmd;
  logic [BLK_W-1:0]        blk;
  logic                    blk_ok;
  logic                    ent_we, ent_re;
  logic [ENT_AW-1:0]       ent_addr;
  logic [CNT_W-1:0]        ent_pos;
  logic                    hdr_we, hdr_re;
  logic [BLK_W-1:0]        ent_rdata_q;
  bfla_pkg::hdr_t          hdr_rdata_q;

  bfla_pkg::hdr_t   hdr_mem [bfla_pkg::NUM_BLOCKS];
  logic [BLK_W-1:0] ent_mem [bfla_pkg::ENT_DEPTH];

  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd    = bfla_pkg::cmd_e'(s_axis_tuser_i[0]);
  assign blk    = s_axis_tdata_i[BLK_W-1:0];
  assign blk_ok = 32'(blk) < 32'(bfla_pkg::NUM_BLOCKS);

  assign ent_addr = ENT_AW'(head_q) * ENT_AW'(bfla_pkg::NODE_CAPACITY) + ENT_AW'(ent_pos);

  always_comb begin
    state_d      = state_q;
    head_valid_d = head_valid_q;
    head_d       = head_q;
    hdr_d        = hdr_q;
    out_valid_d  = out_valid_q;
    out_block_d  = out_block_q;
    out_err_d    = out_err_q;
    out_empty_d  = out_empty_q;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_pos      = hdr_q.cnt;
    hdr_we       = 1'b0;
    hdr_re       = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (cmd)
            bfla_pkg::CMD_FREE: begin
              out_valid_d = 1'b1;
              out_block_d = '0;
              out_err_d   = 1'b0;
              out_empty_d = !head_valid_q;
              if (blk_ok) begin
                out_empty_d = 1'b0;
                if (head_valid_q && (32'(hdr_q.cnt) < 32'(bfla_pkg::NODE_CAPACITY))) begin
                  ent_we    = 1'b1;
                  hdr_we    = 1'b1;
                  hdr_d.cnt = hdr_q.cnt + CNT_W'(1);
                end else begin
                  // The freed block becomes the new head node, linked to the old head.
                  hdr_we         = 1'b1;
                  hdr_d.link_vld = head_valid_q;
                  hdr_d.link     = head_valid_q ? head_q : '0;
                  hdr_d.cnt      = '0;
                  head_d         = blk;
                  head_valid_d   = 1'b1;
                end
              end
            end
            default: begin
              if (!head_valid_q) begin
                out_valid_d = 1'b1;
                out_block_d = '0;
                out_err_d   = 1'b1;
                out_empty_d = 1'b1;
              end else if (hdr_q.cnt != '0) begin
                ent_re    = 1'b1;
                hdr_we    = 1'b1;
                ent_pos   = hdr_q.cnt - CNT_W'(1);
                hdr_d.cnt = hdr_q.cnt - CNT_W'(1);
                state_d   = S_ENTRY;
              end else begin
                // Empty head node: hand out the node block and follow its link.
                out_valid_d  = 1'b1;
                out_block_d  = head_q;
                out_err_d    = 1'b0;
                out_empty_d  = !hdr_q.link_vld;
                head_valid_d = hdr_q.link_vld;
                head_d       = hdr_q.link_vld ? hdr_q.link : '0;
                if (hdr_q.link_vld) begin
                  hdr_re  = 1'b1;
                  state_d = S_HDR;
                end
              end
            end
          endcase
        end
      end
      S_ENTRY: begin
        out_valid_d = 1'b1;
        out_block_d = ent_rdata_q;
        out_err_d   = 1'b0;
        out_empty_d = 1'b0;
        state_d     = S_IDLE;
      end
      S_HDR: begin
        hdr_d   = hdr_rdata_q;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_valid_q <= 1'b0;
      head_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_valid_q <= head_valid_d;
      head_q       <= head_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q       <= hdr_d;
    out_block_q <= out_block_d;
    out_err_q   <= out_err_d;
    out_empty_q <= out_empty_d;
  end

  // Entry memory: a free writes, an allocate reads.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= blk;
    end
    if (ent_re) begin
      ent_rdata_q <= ent_mem[ent_addr];
    end
  end

  // Header memory: every change of the head header is written through, so a
  // node reached again over any link reads its current header. The next node
  // header is read while its link is followed.
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[head_d] <= hdr_d;
    end
    if (hdr_re) begin
      hdr_rdata_q <= hdr_mem[hdr_q.link];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_empty_q, out_block_q};
  assign m_axis_tuser_o  = out_err_q;

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_q |-> (head_q == '0))
    else $error("empty list with nonzero head");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_q && (state_q != S_HDR) |->
      (32'(hdr_q.cnt) <= 32'(bfla_pkg::NODE_CAPACITY)))
    else $error("head node count beyond capacity");

  a_entry_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENTRY) |-> !out_valid_q)
    else $error("entry data arrived while output register was full");

  a_alloc_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd == bfla_pkg::CMD_ALLOC) && !head_valid_q |=>
      out_valid_q && out_err_q && out_empty_q)
    else $error("allocate on empty list did not flag an error");

  a_free_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd == bfla_pkg::CMD_FREE) && blk_ok |=> head_valid_q && !out_empty_q)
    else $error("list empty after a free");

endmodule

`default_nettype wire

>>> tb/block_free_list_allocator_core_tb.sv
`default_nettype none

module block_free_list_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK_W           = bfla_pkg::BLK_W;
  localparam int NUM_BLOCKS      = bfla_pkg::NUM_BLOCKS;
  localparam int NODE_CAPACITY   = bfla_pkg::NODE_CAPACITY;

  localparam int RANDOM_REQUESTS = 1030;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_AT        = 800;
  localparam int CALM_FROM       = 400;
  localparam int CALM_TO         = 650;

  typedef struct packed {
    bfla_pkg::cmd_e   cmd;
    logic [BLK_W-1:0] blk;
  } free_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic             err;
    logic             empty;
  } alloc_outcome_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data  = '0;
  logic [0:0]  s_user  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  block_free_list_allocator_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the free list: head register plus per-node headers and bodies.
  logic [BLK_W-1:0] head_blk = '0;
  logic             head_vld = 1'b0;
  logic [BLK_W-1:0] node_next     [NUM_BLOCKS];
  logic             node_next_vld [NUM_BLOCKS];
  int unsigned      node_fill     [NUM_BLOCKS];
  logic [BLK_W-1:0] node_slot     [NUM_BLOCKS][NODE_CAPACITY];

  free_req_t      request_q[$];
  alloc_outcome_t outcome_q[$];
  free_req_t      cur_req;
  int             sent_cnt   = 0;
  int             recv_cnt   = 0;
  int             fail_cnt   = 0;
  int             hold_left  = 0;
  bit             hold_done  = 1'b0;
  bit             draining   = 1'b0;
  bit             drain_done = 1'b0;

  function automatic alloc_outcome_t apply_to_free_list(free_req_t r);
    alloc_outcome_t res;
    logic [BLK_W-1:0] h;
    int unsigned c;
    res = '0;
    h = head_blk;
    if (r.cmd == bfla_pkg::CMD_FREE) begin
      if (head_vld && node_fill[h] < NODE_CAPACITY) begin
        node_slot[h][node_fill[h]] = r.blk;
        node_fill[h] = node_fill[h] + 1;
      end else begin
        // The freed block turns into the new head node.
        node_fill[r.blk]     = 0;
        node_next_vld[r.blk] = head_vld;
        node_next[r.blk]     = head_vld ? h : '0;
        head_blk = r.blk;
        head_vld = 1'b1;
      end
    end else if (!head_vld) begin
      res.err = 1'b1;
    end else if (node_fill[h] > 0) begin
      c = node_fill[h] - 1;
      res.blk = node_slot[h][c];
      node_fill[h] = c;
    end else begin
      // An empty head node is handed out itself.
      res.blk  = h;
      head_vld = node_next_vld[h];
      head_blk = head_vld ? node_next[h] : '0;
    end
    res.empty = !head_vld;
    return res;
  endfunction

  task automatic add_req(bfla_pkg::cmd_e c, logic [BLK_W-1:0] b);
    free_req_t r;
    r.cmd = c;
    r.blk = b;
    request_q.push_back(r);
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        outcome_q.push_back(apply_to_free_list(cur_req));
        sent_cnt++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (sent_cnt == DRAIN_AT && !drain_done) begin
          draining = 1'b1;
        end
        if (draining && outcome_q.size() == 0) begin
          draining   = 1'b0;
          drain_done = 1'b1;
        end
        if (draining || request_q.size() == 0 ||
            (!(sent_cnt >= CALM_FROM && sent_cnt < CALM_TO) &&
             $urandom_range(99) < 8)) begin
          s_valid <= 1'b0;
        end else begin
          cur_req = request_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= {{(16 - BLK_W){1'b0}}, cur_req.blk};
          s_user  <= cur_req.cmd;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i) begin
    alloc_outcome_t exp_res;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        recv_cnt++;
        if (outcome_q.size() == 0) begin
          $error("result with no request outstanding: tdata=%h tuser=%b",
                 m_axis_tdata_o, m_axis_tuser_o);
          fail_cnt++;
        end else begin
          exp_res = outcome_q.pop_front();
          if (m_axis_tdata_o[BLK_W-1:0] !== exp_res.blk) begin
            $error("alloc_block: expected %0d, got %0d", exp_res.blk,
                   m_axis_tdata_o[BLK_W-1:0]);
            fail_cnt++;
          end
          if (m_axis_tuser_o[0] !== exp_res.err) begin
            $error("alloc_error: expected %b, got %b", exp_res.err, m_axis_tuser_o[0]);
            fail_cnt++;
          end
          if (m_axis_tdata_o[BLK_W] !== exp_res.empty) begin
            $error("list_empty: expected %b, got %b", exp_res.empty,
                   m_axis_tdata_o[BLK_W]);
            fail_cnt++;
          end
          if (m_axis_tdata_o[15:BLK_W+1] !== '0) begin
            $error("tdata padding: expected 0, got %h", m_axis_tdata_o[15:BLK_W+1]);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (!hold_done && recv_cnt >= HOLD_AT) begin
        // Long stall so the output register stays full and the block refuses further requests.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_ready <= 1'b0;
      end else begin
        m_ready <= (recv_cnt >= CALM_FROM && recv_cnt < CALM_TO) ||
                   ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    int push_pct;
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_FREE, 10'd1023);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_FREE, 10'd5);
    add_req(bfla_pkg::CMD_FREE, 10'd1023);
    add_req(bfla_pkg::CMD_FREE, 10'd0);
    add_req(bfla_pkg::CMD_FREE, 10'd0);
    add_req(bfla_pkg::CMD_FREE, 10'h2AA);
    add_req(bfla_pkg::CMD_FREE, 10'h155);
    add_req(bfla_pkg::CMD_ALLOC, 10'h3FF);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_FREE, 10'd512);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);
    add_req(bfla_pkg::CMD_ALLOC, 10'd0);

    // Alternate filling, draining and mixed stretches so that nodes overflow
    // into new heads and the list empties out again many times.
    push_pct = 50;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) begin
        case ((i / 40) % 3)
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        add_req(bfla_pkg::CMD_FREE, 10'($urandom_range(NUM_BLOCKS - 1)));
      end else begin
        add_req(bfla_pkg::CMD_ALLOC, 10'($urandom));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_valid) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout with %0d results outstanding", outcome_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/bfla_pkg.sv
src/block_free_list_allocator_core.sv
tb/block_free_list_allocator_core_tb.sv
